FILE: sv/dhq_pkg.sv
package dhq_pkg;

  localparam int KEY_W  = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 9;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_RD,
    S_UP_CMP,
    S_RM_LAST,
    S_RM_KEY,
    S_DN_SETUP,
    S_DN_RUN,
    S_DN_DEC,
    S_DONE
  } state_e;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_ROOT,
    RD_LAST,
    RD_PARENT,
    RD_CHILD
  } rd_sel_e;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_KEY,
    WR_RDATA,
    WR_BEST
  } wr_sel_e;

  typedef struct packed {
    logic    start_ins;
    logic    start_rem;
    logic    refuse;
    rd_sel_e rd_sel;
    wr_sel_e wr_sel;
    logic    calc_parent;
    logic    up_move;
    logic    grab_root;
    logic    grab_last;
    logic    dn_setup;
    logic    dn_run;
    logic    dn_move;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_less;
    logic child_ok;
    logic pend;
    logic hit;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/dhq_datapath.sv
module dhq_datapath #(
  parameter int CAPACITY = 256,
  parameter int ARITY    = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_func_i,
  input  logic signed [dhq_pkg::KEY_W-1:0]    in_key_i,
  input  dhq_pkg::cmd_t                       cmd_i,
  output dhq_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [dhq_pkg::KEY_W-1:0]    out_key_o,
  output logic        [dhq_pkg::STAT_W-1:0]   out_status_o,
  output logic        [dhq_pkg::OCC_W-1:0]    out_occ_o
);
  import dhq_pkg::*;

  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LA  = (ARITY > 1) ? $clog2(ARITY) : 1;
  localparam int CIW = AW + LA + 1;
  localparam int KW  = $clog2(ARITY + 1);
  localparam int SH  = AW + LA;
  localparam int RW  = SH + 1;
  localparam int PW  = AW + RW;
  localparam longint RECIP_L = ((longint'(1) << SH) + ARITY - 1) / ARITY;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);

  logic signed [KEY_W-1:0] mem_q [CAPACITY];
  logic signed [KEY_W-1:0] rd_data_q;
  logic signed [KEY_W-1:0] key_q, best_key_q, root_q;
  logic signed [KEY_W-1:0] res_key_q;
  logic        [STAT_W-1:0] res_stat_q;
  logic        [OCC_W-1:0]  res_occ_q;
  logic [CW-1:0]  cnt_q;
  logic [AW-1:0]  pos_q, par_q, best_idx_q, pidx_q;
  logic [CIW-1:0] cidx_q;
  logic [KW-1:0]  kcnt_q;
  logic           pend_q, hit_q, op_q, refused_q, out_valid_q;

  logic                    rd_en, wr_en, child_ok, issue;
  logic [AW-1:0]           rd_addr, pos_m1;
  logic signed [KEY_W-1:0] wr_data;
  logic [PW-1:0]           prod;

  assign child_ok = (cidx_q < CIW'(cnt_q)) && (kcnt_q != KW'(ARITY));
  assign issue    = cmd_i.dn_run && child_ok;
  assign pos_m1   = pos_q - AW'(1);
  assign prod     = PW'(pos_m1) * PW'(RECIP);

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (cmd_i.rd_sel)
      RD_NONE:   rd_en = 1'b0;
      RD_ROOT:   rd_addr = '0;
      RD_LAST:   rd_addr = AW'(cnt_q);
      RD_PARENT: rd_addr = par_q;
      RD_CHILD: begin
        rd_en   = issue;
        rd_addr = cidx_q[AW-1:0];
      end
      default:   rd_en = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_data = key_q;
    unique case (cmd_i.wr_sel)
      WR_NONE:  wr_en = 1'b0;
      WR_KEY:   wr_data = key_q;
      WR_RDATA: wr_data = rd_data_q;
      WR_BEST:  wr_data = best_key_q;
      default:  wr_en = 1'b0;
    endcase
  end

  // heap store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[pos_q] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      op_q        <= FUNC_INSERT;
      refused_q   <= 1'b0;
      out_valid_q <= 1'b0;
      kcnt_q      <= '0;
    end else begin
      if (cmd_i.start_ins) begin
        cnt_q     <= cnt_q + CW'(1);
        op_q      <= FUNC_INSERT;
        refused_q <= 1'b0;
      end
      if (cmd_i.start_rem) begin
        cnt_q     <= cnt_q - CW'(1);
        op_q      <= FUNC_REMOVE;
        refused_q <= 1'b0;
      end
      if (cmd_i.refuse) begin
        op_q      <= in_func_i;
        refused_q <= 1'b1;
      end
      if (cmd_i.dn_setup) begin
        hit_q  <= 1'b0;
        kcnt_q <= '0;
        pend_q <= 1'b0;
      end
      if (cmd_i.dn_run) begin
        pend_q <= issue;
        if (issue) begin
          kcnt_q <= kcnt_q + KW'(1);
        end
        if (pend_q && (best_key_q < rd_data_q)) begin
          hit_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_ins) begin
      key_q <= in_key_i;
      pos_q <= AW'(cnt_q);
    end
    if (cmd_i.calc_parent) begin
      par_q <= prod[SH +: AW];
    end
    if (cmd_i.up_move) begin
      pos_q <= par_q;
    end
    if (cmd_i.grab_root) begin
      root_q <= rd_data_q;
    end
    if (cmd_i.grab_last) begin
      key_q <= rd_data_q;
      pos_q <= '0;
    end
    if (cmd_i.dn_setup) begin
      cidx_q     <= CIW'(ARITY) * CIW'(pos_q) + CIW'(1);
      best_key_q <= key_q;
    end
    if (issue) begin
      cidx_q <= cidx_q + CIW'(1);
      pidx_q <= cidx_q[AW-1:0];
    end
    if (cmd_i.dn_run && pend_q && (best_key_q < rd_data_q)) begin
      best_key_q <= rd_data_q;
      best_idx_q <= pidx_q;
    end
    if (cmd_i.dn_move) begin
      pos_q <= best_idx_q;
    end
    if (cmd_i.emit) begin
      res_occ_q <= OCC_W'(cnt_q);
      if (refused_q) begin
        res_key_q  <= '0;
        res_stat_q <= (op_q == FUNC_REMOVE) ? ST_EMPTY : ST_FULL;
      end else begin
        res_key_q  <= (op_q == FUNC_REMOVE) ? root_q : '0;
        res_stat_q <= ST_DONE;
      end
    end
  end

  always_comb begin
    sts_o.full     = (cnt_q == CW'(CAPACITY));
    sts_o.empty    = (cnt_q == '0);
    sts_o.pos_zero = (pos_q == '0);
    sts_o.up_less  = (rd_data_q < key_q);
    sts_o.child_ok = child_ok;
    sts_o.pend     = pend_q;
    sts_o.hit      = hit_q;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_key_o    = res_key_q;
  assign out_status_o = res_stat_q;
  assign out_occ_o    = res_occ_q;

endmodule

FILE: sv/dhq_ctrl.sv
module dhq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_func_i,
  output logic          in_ready_o,
  input  dhq_pkg::sts_t sts_i,
  output dhq_pkg::cmd_t cmd_o
);
  import dhq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_func_i == FUNC_REMOVE) begin
            if (sts_i.empty) begin
              cmd_o.refuse = 1'b1;
              state_d      = S_DONE;
            end else begin
              cmd_o.start_rem = 1'b1;
              cmd_o.rd_sel    = RD_ROOT;
              state_d         = S_RM_LAST;
            end
          end else begin
            if (sts_i.full) begin
              cmd_o.refuse = 1'b1;
              state_d      = S_DONE;
            end else begin
              cmd_o.start_ins = 1'b1;
              state_d         = S_UP_CHK;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts_i.pos_zero) begin
          cmd_o.wr_sel = WR_KEY;
          state_d      = S_DONE;
        end else begin
          cmd_o.calc_parent = 1'b1;
          state_d           = S_UP_RD;
        end
      end
      S_UP_RD: begin
        cmd_o.rd_sel = RD_PARENT;
        state_d      = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (sts_i.up_less) begin
          cmd_o.wr_sel  = WR_RDATA;
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_CHK;
        end else begin
          cmd_o.wr_sel = WR_KEY;
          state_d      = S_DONE;
        end
      end
      S_RM_LAST: begin
        cmd_o.grab_root = 1'b1;
        cmd_o.rd_sel    = RD_LAST;
        state_d         = S_RM_KEY;
      end
      S_RM_KEY: begin
        cmd_o.grab_last = 1'b1;
        state_d         = sts_i.empty ? S_DONE : S_DN_SETUP;
      end
      S_DN_SETUP: begin
        cmd_o.dn_setup = 1'b1;
        state_d        = S_DN_RUN;
      end
      S_DN_RUN: begin
        cmd_o.dn_run = 1'b1;
        cmd_o.rd_sel = RD_CHILD;
        if (!sts_i.child_ok && !sts_i.pend) begin
          state_d = S_DN_DEC;
        end
      end
      S_DN_DEC: begin
        if (sts_i.hit) begin
          cmd_o.wr_sel  = WR_BEST;
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_SETUP;
        end else begin
          cmd_o.wr_sel = WR_KEY;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: sv/dary_max_heap_queue.sv
// Max-priority queue of signed 32-bit keys, kept as an ARITY-ary heap in a
// store of CAPACITY entries with one write port and one registered read port.
// A request is an insert (tuser 0) or a remove-max (tuser 1). Each request gives
// exactly one result. The result carries the removed key (zero unless a remove
// succeeded), a status (done, insert refused because full, remove refused
// because empty) and the occupancy afterwards. One request is worked at a time,
// and the store's single read port sets the pace. An insert places its key in
// the new last slot and moves it up, one level per parent read and compare,
// ending at the root or below a parent that is not smaller. A remove reads the
// root, then the last entry; unless the store is now empty, the last key starts
// at the root and sinks: at each level every existing child (at most ARITY) is
// read in turn, and the largest child greater than the key moves up into its place.
// Refusals go straight to the result. A finished result waits in an output
// register, so the next request is taken while it is still unread. A result is
// held back only while the one before it is still unread. No clearing pass
// after reset.
module dary_max_heap_queue #(
  parameter int CAPACITY = 256,
  parameter int ARITY    = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // key_in[31:0]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // key_out[31:0], occupancy[40:32], zero[47:41]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);
  import dhq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic signed [KEY_W-1:0]  out_key;
  logic        [STAT_W-1:0] out_status;
  logic        [OCC_W-1:0]  out_occ;

  dhq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_func_i  (s_axis_tuser[0]),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dhq_datapath #(
    .CAPACITY (CAPACITY),
    .ARITY    (ARITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_func_i    (s_axis_tuser[0]),
    .in_key_i     (s_axis_tdata),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_key_o    (out_key),
    .out_status_o (out_status),
    .out_occ_o    (out_occ)
  );

  assign m_axis_tdata = {7'd0, out_occ, out_key};
  assign m_axis_tuser = out_status;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result loaded while output register busy");

  a_refused_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_DONE)) |-> (m_axis_tdata[31:0] == '0))
    else $error("refused request carries a key");

  a_no_write_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> (cmd.wr_sel == WR_NONE))
    else $error("store written while taking a request");

  a_emit_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> s_axis_tready)
    else $error("not ready after delivering a result");

endmodule
